@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the thermostat RTL
// Clocked property checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Check a property on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/nht_pkg.sv @@
// ----------------------------------------------------------------------------
// nht_pkg
// Types, constants and helpers of the Nose-Hoover thermostat step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nht_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int NUM_GROUPS = 2;
	localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

	localparam int VAL_W      = 48;
	localparam int WIDE_W     = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int SCALE_W    = 32;
	localparam int SHIFT_W    = 6;

	// Shared multiplier: 62-bit magnitude times 48-bit operand, 16 bits a cycle
	localparam int MUL_A_W    = 62;
	localparam int MUL_B_W    = 48;
	localparam int MUL_DIG_W  = 16;
	localparam int MUL_DIGITS = MUL_B_W / MUL_DIG_W;
	localparam int MUL_CNT_W  = $clog2(MUL_DIGITS + 1);
	localparam int MUL_ACC_W  = MUL_A_W + MUL_B_W;

	// Shared divider: one quotient bit a cycle
	localparam int DIV_N_W    = MUL_A_W + FRAC_BITS;
	localparam int DIV_D_W    = 62;
	localparam int DIV_CNT_W  = $clog2(DIV_N_W + 1);

	localparam logic [31:0]              KB_Q32    = 32'd35710345;
	localparam logic [MUL_A_W-1:0]       CLAMP_MAG = MUL_A_W'(1) << 61;
	localparam logic signed [WIDE_W-1:0] CLAMP_LIM = 64'sh2000_0000_0000_0000;
	localparam logic signed [WIDE_W-1:0] MAX48     = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [WIDE_W-1:0] MIN48     = 64'shFFFF_8000_0000_0000;
	localparam logic signed [WIDE_W-1:0] ONE_Q30_W = 64'sh0000_0000_4000_0000;
	localparam logic signed [WIDE_W-1:0] SCALE_MAX_W = 64'sh0000_0000_FFFF_FFFF;
	localparam logic [SCALE_W-1:0]       ONE_Q30   = 32'h4000_0000;
	localparam logic [SCALE_W-1:0]       SCALE_MAX = 32'hFFFF_FFFF;
	localparam logic [DIV_N_W-1:0]       END_NUM   = DIV_N_W'(1) << 60;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIME_STEP,
		CFG_REF_TEMP_0,
		CFG_REF_TEMP_1,
		CFG_INV_MASS_0,
		CFG_INV_MASS_1,
		CFG_NDOF_0,
		CFG_NDOF_1,
		CFG_COUPLING
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_ACCEL,
		OP_VEL,
		OP_POS,
		OP_SCALE,
		OP_EK1,
		OP_EK2,
		OP_EK3,
		OP_PT1,
		OP_PT2,
		OP_PT3
	} mul_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ACCEL,
		ST_VEL,
		ST_POS,
		ST_SCALE,
		ST_END_DIV,
		ST_EK1,
		ST_EK2,
		ST_EK3,
		ST_PT1,
		ST_PT2,
		ST_PT3,
		ST_END_WAIT,
		ST_MASS_DIV,
		ST_MASS_WAIT,
		ST_SUM,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic    load;
		logic    mul_start;
		logic    mul_capture;
		mul_op_t mul_op;
		logic    end_div_start;
		logic    end_capture;
		logic    mass_div_start;
		logic    mass_capture;
		logic    sum;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic bypass;
		logic mul_busy;
		logic mul_done;
		logic div_done;
		logic den_pos;
		logic mass_trivial;
	} dp_status_t;

	typedef struct packed {
		logic                    ovf;
		logic signed [VAL_W-1:0] val;
	} sat48_t;

	// Saturate a wide signed value to the 48-bit signed range
	function automatic sat48_t sat48(input logic signed [WIDE_W-1:0] x);
		sat48_t r;
		r.ovf = 1'b0;
		r.val = x[VAL_W-1:0];
		if (x > MAX48) begin
			r.ovf = 1'b1;
			r.val = MAX48[VAL_W-1:0];
		end else if (x < MIN48) begin
			r.ovf = 1'b1;
			r.val = MIN48[VAL_W-1:0];
		end
		return r;
	endfunction

	// Sign-extend a 48-bit value to the wide datapath
	function automatic logic signed [WIDE_W-1:0] sx48(input logic signed [VAL_W-1:0] x);
		return {{(WIDE_W-VAL_W){x[VAL_W-1]}}, x};
	endfunction

endpackage

`default_nettype wire

@@ sv/nht_mul.sv @@
// ----------------------------------------------------------------------------
// nht_mul
// Sign-magnitude multiply, truncating right shift and clamp at +-2^61.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nht_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [nht_pkg::WIDE_W-1:0]    a,
	input  logic        [nht_pkg::MUL_B_W-1:0]   b,
	input  logic        [nht_pkg::SHIFT_W-1:0]   sh,
	output logic                                 busy,
	output logic                                 done,
	output logic signed [nht_pkg::WIDE_W-1:0]    res,
	output logic                                 sat
);

	logic [nht_pkg::WIDE_W-1:0]                        a_abs;
	logic [nht_pkg::MUL_A_W-1:0]                       ma_q;
	logic [nht_pkg::MUL_B_W-1:0]                       b_q;
	logic [nht_pkg::SHIFT_W-1:0]                       sh_q;
	logic                                              neg_q;
	logic [nht_pkg::MUL_ACC_W-1:0]                     acc_q;
	logic [nht_pkg::MUL_CNT_W-1:0]                     cnt_q;
	logic                                              busy_q;
	logic [nht_pkg::MUL_A_W+nht_pkg::MUL_DIG_W-1:0]    prod;
	logic [nht_pkg::MUL_ACC_W-1:0]                     shifted;
	logic [nht_pkg::MUL_A_W-1:0]                       mag;
	logic                                              last;

	assign a_abs = a[nht_pkg::WIDE_W-1] ? (~a + 1'b1) : a;
	assign last  = (cnt_q == nht_pkg::MUL_CNT_W'(nht_pkg::MUL_DIGITS));
	assign prod  = ma_q * b_q[nht_pkg::MUL_B_W-1 -: nht_pkg::MUL_DIG_W];

	// Sequence the digits of b, top digit first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Accumulate one partial product a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a_abs[nht_pkg::MUL_A_W-1:0];
			b_q   <= b;
			sh_q  <= sh;
			neg_q <= a[nht_pkg::WIDE_W-1];
			acc_q <= '0;
		end else if (busy_q && !last) begin
			acc_q <= (acc_q << nht_pkg::MUL_DIG_W) + nht_pkg::MUL_ACC_W'(prod);
			b_q   <= b_q << nht_pkg::MUL_DIG_W;
		end
	end

	// Scale down, clamp and restore the sign
	always_comb begin
		shifted = acc_q >> sh_q;
		sat     = (shifted > nht_pkg::MUL_ACC_W'(nht_pkg::CLAMP_MAG));
		mag     = sat ? nht_pkg::CLAMP_MAG : shifted[nht_pkg::MUL_A_W-1:0];
		res     = neg_q ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
	end

	assign busy = busy_q;
	assign done = busy_q && last;

endmodule

`default_nettype wire

@@ sv/nht_div.sv @@
// ----------------------------------------------------------------------------
// nht_div
// Restoring divider, one quotient bit a cycle; result holds until restart.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nht_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [nht_pkg::DIV_N_W-1:0]    num,
	input  logic [nht_pkg::DIV_D_W-1:0]    den,
	output logic                           done,
	output logic [nht_pkg::DIV_N_W-1:0]    quot
);

	logic [nht_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [nht_pkg::DIV_N_W-1:0]   nq_q;
	logic [nht_pkg::DIV_D_W-1:0]   den_q;
	logic [nht_pkg::DIV_D_W-1:0]   rem_q;
	logic [nht_pkg::DIV_D_W:0]     rem_sh;
	logic [nht_pkg::DIV_D_W:0]     rem_sub;
	logic                          qbit;

	assign done = (cnt_q == nht_pkg::DIV_CNT_W'(nht_pkg::DIV_N_W));

	// Count iterations; idle with the count at its end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= nht_pkg::DIV_CNT_W'(nht_pkg::DIV_N_W);
		end else if (start) begin
			cnt_q <= '0;
		end else if (!done) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Shift in one dividend bit and try the subtraction
	always_comb begin
		rem_sh  = {rem_q, nq_q[nht_pkg::DIV_N_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		qbit    = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (!done) begin
			rem_q <= qbit ? rem_sub[nht_pkg::DIV_D_W-1:0] : rem_sh[nht_pkg::DIV_D_W-1:0];
			nq_q  <= {nq_q[nht_pkg::DIV_N_W-2:0], qbit};
		end
	end

	assign quot = nq_q;

endmodule

`default_nettype wire

@@ sv/nht_ctrl.sv @@
// ----------------------------------------------------------------------------
// nht_ctrl
// Sequencer of the thermostat step: issues datapath commands per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nht_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_stall,
	input  nht_pkg::dp_status_t  sts,
	output nht_pkg::dp_cmd_t     cmd,
	output logic                 in_stall,
	output logic                 out_valid
);

	nht_pkg::ctrl_state_t state_q, state_d, nxt_mul;
	logic                 issued_q, issued_d;
	logic                 out_valid_q, out_valid_d;
	logic                 mul_state;

	// State, issue flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nht_pkg::ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			issued_q    <= issued_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands
	always_comb begin
		cmd        = '0;
		cmd.mul_op = nht_pkg::OP_ACCEL;
		state_d    = state_q;
		issued_d   = issued_q;
		mul_state  = 1'b0;
		nxt_mul    = nht_pkg::ST_IDLE;

		unique case (state_q)
			nht_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = nht_pkg::ST_CHECK;
				end
			end
			nht_pkg::ST_CHECK: begin
				state_d = sts.bypass ? nht_pkg::ST_OUT : nht_pkg::ST_ACCEL;
			end
			nht_pkg::ST_ACCEL: begin
				cmd.mul_op = nht_pkg::OP_ACCEL;
				mul_state  = 1'b1;
				nxt_mul    = nht_pkg::ST_VEL;
			end
			nht_pkg::ST_VEL: begin
				cmd.mul_op = nht_pkg::OP_VEL;
				mul_state  = 1'b1;
				nxt_mul    = nht_pkg::ST_POS;
			end
			nht_pkg::ST_POS: begin
				cmd.mul_op = nht_pkg::OP_POS;
				mul_state  = 1'b1;
				nxt_mul    = nht_pkg::ST_SCALE;
			end
			nht_pkg::ST_SCALE: begin
				cmd.mul_op = nht_pkg::OP_SCALE;
				mul_state  = 1'b1;
				nxt_mul    = nht_pkg::ST_END_DIV;
			end
			nht_pkg::ST_END_DIV: begin
				cmd.end_div_start = 1'b1;
				state_d           = nht_pkg::ST_EK1;
			end
			nht_pkg::ST_EK1: begin
				cmd.mul_op = nht_pkg::OP_EK1;
				mul_state  = 1'b1;
				nxt_mul    = nht_pkg::ST_EK2;
			end
			nht_pkg::ST_EK2: begin
				cmd.mul_op = nht_pkg::OP_EK2;
				mul_state  = 1'b1;
				nxt_mul    = nht_pkg::ST_EK3;
			end
			nht_pkg::ST_EK3: begin
				cmd.mul_op = nht_pkg::OP_EK3;
				mul_state  = 1'b1;
				nxt_mul    = nht_pkg::ST_PT1;
			end
			nht_pkg::ST_PT1: begin
				cmd.mul_op = nht_pkg::OP_PT1;
				mul_state  = 1'b1;
				nxt_mul    = nht_pkg::ST_PT2;
			end
			nht_pkg::ST_PT2: begin
				cmd.mul_op = nht_pkg::OP_PT2;
				mul_state  = 1'b1;
				nxt_mul    = nht_pkg::ST_PT3;
			end
			nht_pkg::ST_PT3: begin
				cmd.mul_op = nht_pkg::OP_PT3;
				mul_state  = 1'b1;
				nxt_mul    = nht_pkg::ST_END_WAIT;
			end
			nht_pkg::ST_END_WAIT: begin
				if (!sts.den_pos) begin
					state_d = nht_pkg::ST_MASS_DIV;
				end else if (sts.div_done) begin
					cmd.end_capture = 1'b1;
					state_d         = nht_pkg::ST_MASS_DIV;
				end
			end
			nht_pkg::ST_MASS_DIV: begin
				cmd.mass_div_start = 1'b1;
				state_d = sts.mass_trivial ? nht_pkg::ST_SUM : nht_pkg::ST_MASS_WAIT;
			end
			nht_pkg::ST_MASS_WAIT: begin
				if (sts.div_done) begin
					cmd.mass_capture = 1'b1;
					state_d          = nht_pkg::ST_SUM;
				end
			end
			nht_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = nht_pkg::ST_OUT;
			end
			nht_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = nht_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nht_pkg::ST_IDLE;
			end
		endcase

		// Shared multiply handshake: start once, capture on done
		if (mul_state) begin
			if (!issued_q) begin
				cmd.mul_start = 1'b1;
				issued_d      = 1'b1;
			end else if (sts.mul_done) begin
				cmd.mul_capture = 1'b1;
				issued_d        = 1'b0;
				state_d         = nxt_mul;
			end
		end

		// Hold the result until taken
		if (cmd.out_load) begin
			out_valid_d = 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign in_stall  = (state_q != nht_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ sv/nht_dp.sv @@
// ----------------------------------------------------------------------------
// nht_dp
// Thermostat datapath: configuration, group state, shared multiply and
// divide units, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nht_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic        [nht_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [nht_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                                  group,
	input  logic signed [nht_pkg::VAL_W-1:0]      kinetic_energy,
	input  logic signed [nht_pkg::VAL_W-1:0]      temperature,
	input  nht_pkg::dp_cmd_t                      cmd,
	output nht_pkg::dp_status_t                   sts,
	output logic        [nht_pkg::SCALE_W-1:0]    start_scale,
	output logic        [nht_pkg::SCALE_W-1:0]    end_scale,
	output logic signed [nht_pkg::VAL_W-1:0]      integral,
	output logic signed [nht_pkg::VAL_W:0]        total_integral,
	output logic                                  bypassed,
	output logic                                  overflow
);

	localparam int W = nht_pkg::WIDE_W;
	localparam int V = nht_pkg::VAL_W;
	localparam int S = nht_pkg::SCALE_W;

	// Configuration
	logic [S-1:0]                    time_step_q;
	logic [S-1:0]                    ref_temp_q [nht_pkg::NUM_GROUPS];
	logic [V-1:0]                    inv_mass_q [nht_pkg::NUM_GROUPS];
	logic [V-1:0]                    ndof_q     [nht_pkg::NUM_GROUPS];
	logic [nht_pkg::NUM_GROUPS-1:0]  coupling_q;

	// Thermostat state per group
	logic signed [V-1:0] pos_q   [nht_pkg::NUM_GROUPS];
	logic signed [V-1:0] vel_q   [nht_pkg::NUM_GROUPS];
	logic signed [V-1:0] integ_q [nht_pkg::NUM_GROUPS];

	// Per-item working registers
	logic [nht_pkg::GRP_W-1:0] grp_q;
	logic signed [V-1:0]       temp_q;
	logic                      byp_q;
	logic                      ovf_q;
	logic signed [V-1:0]       accel_q;
	logic signed [V-1:0]       vnew_q;
	logic signed [V-1:0]       xi_q;
	logic signed [W-1:0]       den_q;
	logic                      den_pos_q;
	logic [S-1:0]              start_q;
	logic [S-1:0]              end_q;
	logic signed [W-1:0]       e_q;
	logic signed [W-1:0]       t1_q;
	logic signed [W-1:0]       t2_q;
	logic signed [V-1:0]       item_integ_q;

	// Result register
	logic [S-1:0]        start_out_q;
	logic [S-1:0]        end_out_q;
	logic signed [V-1:0] integ_out_q;
	logic signed [V:0]   total_out_q;
	logic                byp_out_q;
	logic                ovf_out_q;

	// Unit interfaces
	logic signed [W-1:0]                 mul_a;
	logic [nht_pkg::MUL_B_W-1:0]         mul_b;
	logic [nht_pkg::SHIFT_W-1:0]         mul_sh;
	logic                                mul_busy;
	logic                                mul_done;
	logic signed [W-1:0]                 mul_res;
	logic                                mul_sat;
	logic                                div_start;
	logic [nht_pkg::DIV_N_W-1:0]         div_num;
	logic [nht_pkg::DIV_D_W-1:0]         div_den;
	logic                                div_done;
	logic [nht_pkg::DIV_N_W-1:0]         div_quot;

	// Group selections and derived values
	logic [S-1:0]        cur_ref;
	logic [V-1:0]        cur_mass;
	logic [V-1:0]        cur_ndof;
	logic signed [V-1:0] cur_vold;
	logic signed [V-1:0] cur_pos;
	logic signed [W-1:0] vabs;
	logic                mass_trivial;
	logic signed [W-1:0] vel_sum;
	logic signed [W-1:0] pos_sum;
	logic signed [W-1:0] scale_s;
	logic signed [W-1:0] scale_den;
	logic signed [W-1:0] integ_sum;
	nht_pkg::sat48_t     sat_accel;
	nht_pkg::sat48_t     sat_vel;
	nht_pkg::sat48_t     sat_pos;
	nht_pkg::sat48_t     sat_integ;
	logic signed [V:0]   total_sum;

	assign cur_ref      = ref_temp_q[grp_q];
	assign cur_mass     = inv_mass_q[grp_q];
	assign cur_ndof     = ndof_q[grp_q];
	assign cur_vold     = vel_q[grp_q];
	assign cur_pos      = pos_q[grp_q];
	assign vabs         = vnew_q[V-1] ? -nht_pkg::sx48(vnew_q) : nht_pkg::sx48(vnew_q);
	assign mass_trivial = (e_q == '0) || (cur_mass == '0);

	// Operand selection for the shared multiplier
	always_comb begin
		unique case (cmd.mul_op)
			nht_pkg::OP_ACCEL: begin
				mul_a  = nht_pkg::sx48(temp_q) - $signed({{(W-S){1'b0}}, cur_ref});
				mul_b  = cur_mass;
				mul_sh = nht_pkg::SHIFT_W'(nht_pkg::FRAC_BITS);
			end
			nht_pkg::OP_VEL: begin
				mul_a  = nht_pkg::sx48(accel_q);
				mul_b  = nht_pkg::MUL_B_W'(time_step_q);
				mul_sh = nht_pkg::SHIFT_W'(32);
			end
			nht_pkg::OP_POS: begin
				mul_a  = nht_pkg::sx48(cur_vold) + nht_pkg::sx48(vnew_q);
				mul_b  = nht_pkg::MUL_B_W'(time_step_q);
				mul_sh = nht_pkg::SHIFT_W'(33);
			end
			nht_pkg::OP_SCALE: begin
				mul_a  = nht_pkg::sx48(vnew_q);
				mul_b  = nht_pkg::MUL_B_W'(time_step_q);
				mul_sh = nht_pkg::SHIFT_W'(nht_pkg::FRAC_BITS + 3);
			end
			nht_pkg::OP_EK1: begin
				mul_a  = vabs;
				mul_b  = vabs[nht_pkg::MUL_B_W-1:0];
				mul_sh = nht_pkg::SHIFT_W'(nht_pkg::FRAC_BITS);
			end
			nht_pkg::OP_EK2: begin
				mul_a  = e_q;
				mul_b  = cur_ndof;
				mul_sh = nht_pkg::SHIFT_W'(nht_pkg::FRAC_BITS);
			end
			nht_pkg::OP_EK3: begin
				mul_a  = e_q;
				mul_b  = nht_pkg::MUL_B_W'(nht_pkg::KB_Q32);
				mul_sh = nht_pkg::SHIFT_W'(33);
			end
			nht_pkg::OP_PT1: begin
				mul_a  = nht_pkg::sx48(xi_q);
				mul_b  = cur_ndof;
				mul_sh = nht_pkg::SHIFT_W'(nht_pkg::FRAC_BITS);
			end
			nht_pkg::OP_PT2: begin
				mul_a  = t2_q;
				mul_b  = nht_pkg::MUL_B_W'(cur_ref);
				mul_sh = nht_pkg::SHIFT_W'(nht_pkg::FRAC_BITS);
			end
			nht_pkg::OP_PT3: begin
				mul_a  = t2_q;
				mul_b  = nht_pkg::MUL_B_W'(nht_pkg::KB_Q32);
				mul_sh = nht_pkg::SHIFT_W'(32);
			end
			default: begin
				mul_a  = '0;
				mul_b  = '0;
				mul_sh = '0;
			end
		endcase
	end

	nht_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.sh     (mul_sh),
		.busy   (mul_busy),
		.done   (mul_done),
		.res    (mul_res),
		.sat    (mul_sat)
	);

	// Divider: end scale first, then the mass term
	assign div_start = (cmd.end_div_start && den_pos_q) || (cmd.mass_div_start && !mass_trivial);
	assign div_num   = cmd.mass_div_start ?
		{e_q[nht_pkg::MUL_A_W-1:0], {nht_pkg::FRAC_BITS{1'b0}}} : nht_pkg::END_NUM;
	assign div_den   = cmd.mass_div_start ?
		nht_pkg::DIV_D_W'(cur_mass) : den_q[nht_pkg::DIV_D_W-1:0];

	nht_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Capture arithmetic
	always_comb begin
		sat_accel = nht_pkg::sat48(mul_res);
		vel_sum   = nht_pkg::sx48(cur_vold) + mul_res;
		sat_vel   = nht_pkg::sat48(vel_sum);
		pos_sum   = nht_pkg::sx48(cur_pos) + mul_res;
		sat_pos   = nht_pkg::sat48(pos_sum);
		scale_s   = nht_pkg::ONE_Q30_W - mul_res;
		scale_den = nht_pkg::ONE_Q30_W + mul_res;
		integ_sum = t1_q + t2_q;
		sat_integ = nht_pkg::sat48(integ_sum);
		total_sum = '0;
		for (int i = 0; i < nht_pkg::NUM_GROUPS; i++) begin
			total_sum = total_sum + {integ_q[i][V-1], integ_q[i]};
		end
	end

	// Configuration and group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= '0;
			coupling_q  <= '0;
			for (int i = 0; i < nht_pkg::NUM_GROUPS; i++) begin
				ref_temp_q[i] <= '0;
				inv_mass_q[i] <= '0;
				ndof_q[i]     <= '0;
				pos_q[i]      <= '0;
				vel_q[i]      <= '0;
				integ_q[i]    <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (nht_pkg::cfg_idx_t'(cfg_index))
					nht_pkg::CFG_TIME_STEP:  time_step_q   <= cfg_data[S-1:0];
					nht_pkg::CFG_REF_TEMP_0: ref_temp_q[0] <= cfg_data[S-1:0];
					nht_pkg::CFG_REF_TEMP_1: ref_temp_q[1] <= cfg_data[S-1:0];
					nht_pkg::CFG_INV_MASS_0: inv_mass_q[0] <= cfg_data[V-1:0];
					nht_pkg::CFG_INV_MASS_1: inv_mass_q[1] <= cfg_data[V-1:0];
					nht_pkg::CFG_NDOF_0:     ndof_q[0]     <= cfg_data[V-1:0];
					nht_pkg::CFG_NDOF_1:     ndof_q[1]     <= cfg_data[V-1:0];
					nht_pkg::CFG_COUPLING:
						coupling_q <= cfg_data[nht_pkg::NUM_GROUPS-1:0];
					default: ;
				endcase
			end
			if (cmd.sum) begin
				vel_q[grp_q]   <= vnew_q;
				pos_q[grp_q]   <= xi_q;
				integ_q[grp_q] <= sat_integ.val;
			end
		end
	end

	// Per-item work registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			grp_q  <= group;
			temp_q <= temperature;
			ovf_q  <= 1'b0;
			byp_q  <= !coupling_q[group] || (ndof_q[group] == '0) ||
				(kinetic_energy <= $signed(48'sd0));
		end

		if (cmd.mul_capture) begin
			unique case (cmd.mul_op)
				nht_pkg::OP_ACCEL: begin
					accel_q <= sat_accel.val;
					ovf_q   <= ovf_q | mul_sat | sat_accel.ovf;
				end
				nht_pkg::OP_VEL: begin
					vnew_q <= sat_vel.val;
					ovf_q  <= ovf_q | mul_sat | sat_vel.ovf;
				end
				nht_pkg::OP_POS: begin
					xi_q  <= sat_pos.val;
					ovf_q <= ovf_q | mul_sat | sat_pos.ovf;
				end
				nht_pkg::OP_SCALE: begin
					den_q     <= scale_den;
					den_pos_q <= (scale_den > $signed(64'sd0));
					if (scale_s < $signed(64'sd0)) begin
						start_q <= '0;
						ovf_q   <= 1'b1;
					end else if (scale_s > nht_pkg::SCALE_MAX_W) begin
						start_q <= nht_pkg::SCALE_MAX;
						ovf_q   <= 1'b1;
					end else begin
						start_q <= scale_s[S-1:0];
						ovf_q   <= ovf_q | mul_sat;
					end
				end
				nht_pkg::OP_EK1, nht_pkg::OP_EK2, nht_pkg::OP_EK3: begin
					e_q   <= mul_res;
					ovf_q <= ovf_q | mul_sat;
				end
				nht_pkg::OP_PT1, nht_pkg::OP_PT2, nht_pkg::OP_PT3: begin
					t2_q  <= mul_res;
					ovf_q <= ovf_q | mul_sat;
				end
				default: ;
			endcase
		end

		// Non-positive end divisor saturates at once
		if (cmd.end_div_start && !den_pos_q) begin
			end_q <= nht_pkg::SCALE_MAX;
			ovf_q <= 1'b1;
		end

		if (cmd.end_capture) begin
			if (div_quot[nht_pkg::DIV_N_W-1:S] != '0) begin
				end_q <= nht_pkg::SCALE_MAX;
				ovf_q <= 1'b1;
			end else begin
				end_q <= div_quot[S-1:0];
			end
		end

		// Mass term: zero energy gives zero, zero mass saturates
		if (cmd.mass_div_start) begin
			if (e_q == '0) begin
				t1_q <= '0;
			end else if (cur_mass == '0) begin
				t1_q  <= nht_pkg::CLAMP_LIM;
				ovf_q <= 1'b1;
			end
		end

		if (cmd.mass_capture) begin
			if (div_quot[nht_pkg::DIV_N_W-1:61] != '0) begin
				t1_q  <= nht_pkg::CLAMP_LIM;
				ovf_q <= 1'b1;
			end else begin
				t1_q <= $signed({{(W-61){1'b0}}, div_quot[60:0]});
			end
		end

		if (cmd.sum) begin
			item_integ_q <= sat_integ.val;
			ovf_q        <= ovf_q | sat_integ.ovf;
		end

		// Result register
		if (cmd.out_load) begin
			start_out_q <= byp_q ? nht_pkg::ONE_Q30 : start_q;
			end_out_q   <= byp_q ? nht_pkg::ONE_Q30 : end_q;
			integ_out_q <= byp_q ? integ_q[grp_q] : item_integ_q;
			total_out_q <= total_sum;
			byp_out_q   <= byp_q;
			ovf_out_q   <= byp_q ? 1'b0 : ovf_q;
		end
	end

	assign sts.bypass       = byp_q;
	assign sts.mul_busy     = mul_busy;
	assign sts.mul_done     = mul_done;
	assign sts.div_done     = div_done;
	assign sts.den_pos      = den_pos_q;
	assign sts.mass_trivial = mass_trivial;

	assign start_scale    = start_out_q;
	assign end_scale      = end_out_q;
	assign integral       = integ_out_q;
	assign total_integral = total_out_q;
	assign bypassed       = byp_out_q;
	assign overflow       = ovf_out_q;

endmodule

`default_nettype wire

@@ sv/nose_hoover_thermostat_step.sv @@
// ----------------------------------------------------------------------------
// nose_hoover_thermostat_step
// Leap-frog Nose-Hoover thermostat update for one temperature group per item.
// ----------------------------------------------------------------------------
// One item is in work at a time. A coupled item runs ten multiplies on the
// shared multiplier and at most two passes of the one-bit-a-cycle divider over
// 78 quotient bits; the end-scale division overlaps the energy and potential
// multiplies, the mass division does not and is skipped when the energy term
// or the inverse mass is zero. The next item is accepted as soon as the
// result sits in the output register, even while that result is still
// stalled. Configuration writes are always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nose_hoover_thermostat_step (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [nht_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [nht_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  group,
	input  logic signed [nht_pkg::VAL_W-1:0]      kinetic_energy,
	input  logic signed [nht_pkg::VAL_W-1:0]      temperature,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic        [nht_pkg::SCALE_W-1:0]    start_scale,
	output logic        [nht_pkg::SCALE_W-1:0]    end_scale,
	output logic signed [nht_pkg::VAL_W-1:0]      integral,
	output logic signed [nht_pkg::VAL_W:0]        total_integral,
	output logic                                  bypassed,
	output logic                                  overflow
);

	nht_pkg::dp_cmd_t    cmd;
	nht_pkg::dp_status_t sts;

	assign cfg_ready = 1'b1;

	nht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	nht_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.group          (group),
		.kinetic_energy (kinetic_energy),
		.temperature    (temperature),
		.cmd            (cmd),
		.sts            (sts),
		.start_scale    (start_scale),
		.end_scale      (end_scale),
		.integral       (integral),
		.total_integral (total_integral),
		.bypassed       (bypassed),
		.overflow       (overflow)
	);

	// Checks
	`ASSERT_CLK(a_one_item_in_work, clk, arst_n, in_valid && !in_stall |=> in_stall, "item accepted while busy")
	`ASSERT_CLK(a_out_load_free, clk, arst_n, cmd.out_load |-> !out_valid || !out_stall, "result overwritten")
	`ASSERT_CLK(a_mul_idle_on_start, clk, arst_n, cmd.mul_start |-> !sts.mul_busy, "multiply restarted while busy")
	`ASSERT_CLK(a_bypass_unity, clk, arst_n, out_valid && bypassed |-> start_scale == nht_pkg::ONE_Q30 && end_scale == nht_pkg::ONE_Q30 && !overflow, "bypassed item with scaling")
	`ASSERT_CLK_ALWAYS(a_reset_idle, clk, !arst_n |=> !out_valid && !in_stall, "not idle after reset")

endmodule

`default_nettype wire

@@ dv/nht_checker.sv @@
// ----------------------------------------------------------------------------
// nht_checker
// Watches the configuration, item and result channels of the thermostat step
// block, predicts each result from its own copy of registers and state, and
// compares every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nht_checker
	import nht_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         group,
	input  logic signed [VAL_W-1:0]      kinetic_energy,
	input  logic signed [VAL_W-1:0]      temperature,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [SCALE_W-1:0]           start_scale,
	input  logic [SCALE_W-1:0]           end_scale,
	input  logic signed [VAL_W-1:0]      integral,
	input  logic signed [VAL_W:0]        total_integral,
	input  logic                         bypassed,
	input  logic                         overflow,
	output int                           fail_count,
	output int                           pending
);

	typedef logic signed [63:0] s64_t;

	typedef struct {
		logic [31:0] start_s;
		logic [31:0] end_s;
		logic [47:0] integ;
		logic [48:0] total;
		logic        byp;
		logic        ovf;
	} thermo_result_t;

	localparam s64_t LIM61 = 64'sd1 <<< 61;
	localparam s64_t HI48  = (64'sd1 <<< 47) - 1;
	localparam s64_t LO48  = -(64'sd1 <<< 47);

	// Register copies
	logic [31:0] dt, tref [2];
	logic [47:0] minv [2], dof [2];
	logic [1:0]  coup_en;

	// Thermostat state copies
	s64_t xi_st [2], v_st [2], integ_st [2];

	thermo_result_t scale_q [$];
	int             mism;

	assign pending = scale_q.size();
	assign fail_count = mism;

	// Magnitude product shifted right, clamped at 2^61
	function automatic s64_t mul_shr(input s64_t a, input logic [63:0] b, input int sh,
		inout bit ovf);
		logic [63:0]  ma, r;
		logic [127:0] p;
		ma = (a < 0) ? 64'(-a) : 64'(a);
		p  = ({64'd0, ma} * {64'd0, b}) >> sh;
		r  = p[63:0];
		if ((|p[127:63]) || r > 64'(LIM61)) begin
			ovf = 1'b1;
			r   = 64'(LIM61);
		end
		return (a < 0) ? -$signed(r) : $signed(r);
	endfunction

	function automatic s64_t clip48(input s64_t x, inout bit ovf);
		if (x > HI48) begin
			ovf = 1'b1;
			return HI48;
		end
		if (x < LO48) begin
			ovf = 1'b1;
			return LO48;
		end
		return x;
	endfunction

	// Energy over inverse mass, with FRAC_BITS of fraction
	function automatic s64_t energy_div(input logic [63:0] e, input logic [63:0] m,
		inout bit ovf);
		logic [127:0] q;
		if (e == 0)
			return 0;
		if (m == 0 || (e / m) >> (61 - FRAC_BITS) != 0) begin
			ovf = 1'b1;
			return LIM61;
		end
		q = ({64'd0, e} << FRAC_BITS) / {64'd0, m};
		if (q > 128'(LIM61)) begin
			ovf = 1'b1;
			return LIM61;
		end
		return $signed(q[63:0]);
	endfunction

	// Advance one group by a leap-frog step unless bypassed, and form its result
	function automatic thermo_result_t leapfrog_step(input logic g, input s64_t ke,
		input s64_t temp);
		thermo_result_t res;
		bit   ovf;
		s64_t accel, vold, vnew, xi, x, s, den, t1, t2, e, av, integ;
		ovf = 1'b0;
		if (!coup_en[g] || dof[g] == 0 || ke <= 0) begin
			res.start_s = ONE_Q30;
			res.end_s   = ONE_Q30;
			integ       = integ_st[g];
			res.byp     = 1'b1;
		end else begin
			res.byp = 1'b0;
			accel = clip48(mul_shr(temp - $signed({32'd0, tref[g]}), {16'd0, minv[g]},
				FRAC_BITS, ovf), ovf);
			vold  = v_st[g];
			vnew  = clip48(vold + mul_shr(accel, {32'd0, dt}, 32, ovf), ovf);
			xi    = clip48(xi_st[g] + mul_shr(vold + vnew, {32'd0, dt}, 33, ovf), ovf);
			v_st[g]  = vnew;
			xi_st[g] = xi;
			// scale factors around one, Q2.30
			x = mul_shr(vnew, {32'd0, dt}, FRAC_BITS + 3, ovf);
			s = (64'sd1 <<< 30) - x;
			if (s < 0) begin
				ovf = 1'b1;
				res.start_s = 32'd0;
			end else if (s > 64'sh0FFFF_FFFF) begin
				ovf = 1'b1;
				res.start_s = SCALE_MAX;
			end else begin
				res.start_s = s[31:0];
			end
			den = (64'sd1 <<< 30) + x;
			if (den <= 0) begin
				ovf = 1'b1;
				res.end_s = SCALE_MAX;
			end else begin
				e = $signed((64'd1 << 60) / 64'(den));
				if (e > 64'sh0FFFF_FFFF) begin
					ovf = 1'b1;
					res.end_s = SCALE_MAX;
				end else begin
					res.end_s = e[31:0];
				end
			end
			// kinetic and potential parts of the integral
			av = (vnew < 0) ? -vnew : vnew;
			e  = mul_shr(av, 64'(av), FRAC_BITS, ovf);
			e  = mul_shr(e, {16'd0, dof[g]}, FRAC_BITS, ovf);
			e  = mul_shr(e, {32'd0, KB_Q32}, 33, ovf);
			t1 = energy_div(64'(e), {16'd0, minv[g]}, ovf);
			t2 = mul_shr(xi, {16'd0, dof[g]}, FRAC_BITS, ovf);
			t2 = mul_shr(t2, {32'd0, tref[g]}, FRAC_BITS, ovf);
			t2 = mul_shr(t2, {32'd0, KB_Q32}, 32, ovf);
			integ = clip48(t1 + t2, ovf);
			integ_st[g] = integ;
		end
		res.integ = integ[47:0];
		res.total = 49'(integ_st[0] + integ_st[1]);
		res.ovf   = ovf;
		return res;
	endfunction

	// Follow the channels; compare results before queueing new predictions
	always @(posedge clk or negedge arst_n) begin
		thermo_result_t exp_r;
		if (!arst_n) begin
			dt <= '0;
			tref[0] <= '0;
			tref[1] <= '0;
			minv[0] <= '0;
			minv[1] <= '0;
			dof[0] <= '0;
			dof[1] <= '0;
			coup_en <= '0;
			for (int i = 0; i < 2; i++) begin
				xi_st[i] = 0;
				v_st[i] = 0;
				integ_st[i] = 0;
			end
			scale_q.delete();
			mism <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (scale_q.size() == 0) begin
					if (mism < 10)
						$display("%0t: result with no item outstanding", $realtime);
					mism <= mism + 1;
				end else begin
					exp_r = scale_q.pop_front();
					if (start_scale !== exp_r.start_s || end_scale !== exp_r.end_s ||
						integral !== exp_r.integ || total_integral !== exp_r.total ||
						bypassed !== exp_r.byp || overflow !== exp_r.ovf) begin
						if (mism < 10)
							$display("%0t: mismatch exp s=%h e=%h i=%h t=%h b=%b o=%b got s=%h e=%h i=%h t=%h b=%b o=%b",
								$realtime, exp_r.start_s, exp_r.end_s, exp_r.integ,
								exp_r.total, exp_r.byp, exp_r.ovf, start_scale, end_scale,
								integral, total_integral, bypassed, overflow);
						mism <= mism + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				scale_q.push_back(leapfrog_step(group, 64'(kinetic_energy),
					64'(temperature)));
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TIME_STEP:  dt <= cfg_data[31:0];
					CFG_REF_TEMP_0: tref[0] <= cfg_data[31:0];
					CFG_REF_TEMP_1: tref[1] <= cfg_data[31:0];
					CFG_INV_MASS_0: minv[0] <= cfg_data;
					CFG_INV_MASS_1: minv[1] <= cfg_data;
					CFG_NDOF_0:     dof[0] <= cfg_data;
					CFG_NDOF_1:     dof[1] <= cfg_data;
					CFG_COUPLING:   coup_en <= cfg_data[1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives the thermostat step block through directed and random phases of
// register settings and items, with bursty input and patterned output stalls;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import nht_pkg::*;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    group = 1'b0;
	logic signed [VAL_W-1:0] kinetic_energy = '0;
	logic signed [VAL_W-1:0] temperature = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [SCALE_W-1:0]      start_scale, end_scale;
	logic signed [VAL_W-1:0] integral;
	logic signed [VAL_W:0]   total_integral;
	logic                    bypassed, overflow;
	int                      fail_count, pending;
	int                      burst_left = 0;
	logic [31:0]             cur_ref [2];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	nose_hoover_thermostat_step DUT (.*);
	nht_checker u_checker (.*);

	// Receiver stalls: a new pattern each time the counter wraps to zero
	always @(posedge clk) begin
		int mode, cnt;
		if (cnt == 0)
			mode = $urandom_range(0, 3);
		cnt = (cnt + 1) % 64;
		case (mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= ($urandom_range(0, 9) < 8);
			default: out_stall <= cnt[2];
		endcase
	end

	function automatic logic [47:0] rand48();
		return {$urandom, $urandom};
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [47:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold until all results are back, then rewrite every register
	task automatic set_regs(input logic [31:0] ts, input logic [31:0] r0,
		input logic [31:0] r1, input logic [47:0] m0, input logic [47:0] m1,
		input logic [47:0] n0, input logic [47:0] n1, input logic [1:0] en);
		@(posedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(CFG_TIME_STEP, ts);
		write_reg(CFG_REF_TEMP_0, r0);
		write_reg(CFG_REF_TEMP_1, r1);
		write_reg(CFG_INV_MASS_0, m0);
		write_reg(CFG_INV_MASS_1, m1);
		write_reg(CFG_NDOF_0, n0);
		write_reg(CFG_NDOF_1, n1);
		write_reg(CFG_COUPLING, en);
		cur_ref[0] = r0;
		cur_ref[1] = r1;
	endtask

	// Send one item; bursts of random length separated by random gaps
	task automatic send_item(input logic g, input logic [47:0] ke, input logic [47:0] t);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		burst_left--;
		in_valid       <= 1'b1;
		group          <= g;
		kinetic_energy <= ke;
		temperature    <= t;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic random_item();
		logic        g;
		logic [47:0] ke, t;
		g  = $urandom_range(0, 1);
		ke = ($urandom_range(0, 99) < 85) ? {1'b0, 47'(rand48())} >> $urandom_range(0, 40)
			: rand48();
		if ($urandom_range(0, 99) < 70)
			t = 48'({16'd0, cur_ref[g]}) + 48'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		else
			t = rand48();
		send_item(g, ke, t);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Typical coupling: bypass cases and field extremes
		set_regs(32'd8589935, 32'd300 << 16, 32'd310 << 16, 48'd1 << 16, 48'd3 << 15,
			48'd100 << 16, 48'd50 << 16, 2'b11);
		send_item(1'b0, 48'd0, 48'd300 << 16);
		send_item(1'b0, 48'h8000_0000_0000, 48'd300 << 16);
		send_item(1'b0, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
		send_item(1'b0, 48'd1, 48'h8000_0000_0000);
		send_item(1'b1, 48'd5 << 16, 48'd400 << 16);
		send_item(1'b1, 48'd5 << 16, 48'd500 << 16);
		send_item(1'b0, 48'hFFFF_FFFF_FFFF, 48'd0);

		// Zero inverse mass with velocity left over; group 0 disabled
		set_regs(32'd8589935, 32'd300 << 16, 32'd310 << 16, 48'd1 << 16, 48'd0,
			48'd100 << 16, 48'd50 << 16, 2'b10);
		send_item(1'b1, 48'd5 << 16, 48'd310 << 16);
		send_item(1'b0, 48'd5 << 16, 48'd310 << 16);

		// Zero degrees of freedom on group 1
		set_regs(32'd8589935, 32'd300 << 16, 32'd310 << 16, 48'd1 << 16, 48'd1 << 16,
			48'd100 << 16, 48'd0, 2'b11);
		send_item(1'b1, 48'd5 << 16, 48'd310 << 16);
		send_item(1'b0, 48'd5 << 16, 48'd900 << 16);

		// Register maxima: saturating velocity, scales and divisor
		set_regs('1, '1, '1, '1, '1, '1, '1, 2'b11);
		send_item(1'b0, 48'd1, 48'h8000_0000_0000);
		send_item(1'b0, 48'd1, 48'h8000_0000_0000);
		send_item(1'b1, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
		send_item(1'b1, 48'd7, 48'h8000_0000_0000);
		send_item(1'b0, 48'd3, 48'h7FFF_FFFF_FFFF);

		// Everything off
		set_regs('0, '0, '0, '0, '0, '0, '0, 2'b00);
		send_item(1'b0, 48'd9, 48'd9);
		send_item(1'b1, 48'd9, 48'd9);

		// Random settings, mostly moderate, some full range
		for (int ph = 0; ph < 8; ph++) begin
			if (ph % 3 == 2)
				set_regs($urandom, $urandom, $urandom, rand48(), rand48(), rand48(),
					rand48(), $urandom_range(0, 3));
			else
				set_regs($urandom_range(1 << 18, 1 << 26), $urandom_range(0, 1000 << 16),
					$urandom_range(0, 1000 << 16), 48'($urandom_range(0, 1 << 20)),
					48'($urandom_range(0, 1 << 20)), 48'($urandom_range(0, 1 << 26)),
					48'($urandom_range(0, 1 << 26)), ($urandom_range(0, 3) == 0) ? 2'b01 : 2'b11);
			repeat (60) random_item();
		end

		@(posedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#40ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/nht_pkg.sv
sv/nht_mul.sv
sv/nht_div.sv
sv/nht_ctrl.sv
sv/nht_dp.sv
sv/nose_hoover_thermostat_step.sv
dv/nht_checker.sv
dv/tb.sv
